// File: rtl/clit_pkg.sv
// Shared types and constants for the clamped linear interpolation table.
package clit_pkg;

   localparam int VALUE_BITS       = 32;
   localparam int INDEX_BITS       = 10;
   localparam int ENTRY_COUNT_BITS = 11;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int RECIP_BITS       = 32;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_INDEX = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_REFUSED = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RANGE_LOW  = 2'd0,
      CSR_RANGE_HIGH = 2'd1,
      CSR_ENTRIES    = 2'd2
   } csr_index_type;

   typedef struct packed {
      kind_type                      kind;
      logic signed [VALUE_BITS-1:0]  position;
      logic [INDEX_BITS-1:0]         entry_index;
      logic signed [VALUE_BITS-1:0]  entry_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0]  result_value;
      status_type                    status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic take;
      logic eval;
      logic read_a;
      logic read_b;
      logic scale;
      logic deliver;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic wants_div;
      logic wants_read;
      logic div_done;
   } stat_type;

endpackage

// File: rtl/clit_recip_div.sv
// Restoring divider, one quotient bit per cycle, for the spacing reciprocal.
module clit_recip_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [clit_pkg::RECIP_BITS-1:0]  numer,
   input  logic [clit_pkg::RECIP_BITS-1:0]  denom,
   output logic                             done,
   output logic [clit_pkg::RECIP_BITS-1:0]  quotient
);
   import clit_pkg::*;

   localparam int STEP_BITS = $clog2(RECIP_BITS + 1);

   logic [STEP_BITS-1:0]  count_ff;
   logic                  done_ff;
   logic [RECIP_BITS-1:0] rem_ff;
   logic [RECIP_BITS-1:0] denom_ff;
   logic [RECIP_BITS-1:0] quo_ff;

   logic [RECIP_BITS:0]   trial;
   logic [RECIP_BITS:0]   trial_diff;
   logic                  fits;
   logic [RECIP_BITS-1:0] rem_in;
   logic [RECIP_BITS-1:0] quo_in;
   logic                  busy;

   // numer < denom on start, so the quotient is a pure fraction of RECIP_BITS bits
   assign busy       = (count_ff != '0);
   assign trial      = {rem_ff, 1'b0};
   assign trial_diff = trial - {1'b0, denom_ff};
   assign fits       = (trial >= {1'b0, denom_ff});
   assign rem_in     = fits ? trial_diff[RECIP_BITS-1:0] : trial[RECIP_BITS-1:0];
   assign quo_in     = {quo_ff[RECIP_BITS-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= busy && (count_ff == STEP_BITS'(1));
         if (start) begin
            count_ff <= STEP_BITS'(RECIP_BITS);
         end else if (busy) begin
            count_ff <= count_ff - STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= numer;
         denom_ff <= denom;
         quo_ff   <= '0;
      end else if (busy) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/clit_datapath.sv
// Datapath: registers, sample memory, position multiply, blend multiply, reciprocal divider, result register.
module clit_datapath #(
   parameter int TABLE_DEPTH   = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [clit_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [clit_pkg::VALUE_BITS-1:0]      csr_wdata,
   input  clit_pkg::req_type                    req_data,
   input  clit_pkg::cmd_type                    cmd,
   output clit_pkg::stat_type                   stat,
   output clit_pkg::rsp_type                    rsp_data
);
   import clit_pkg::*;

   localparam int NW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = (NW > ENTRY_COUNT_BITS) ? NW : ENTRY_COUNT_BITS;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = 2 * VALUE_BITS;
   localparam int SW = VALUE_BITS + 2 + FRACTION_BITS;
   localparam logic [SW-1:0] ROUND_HALF = SW'(1) << (FRACTION_BITS - 1);

   // configuration and table state
   logic signed [VALUE_BITS-1:0]  low_ff;
   logic signed [VALUE_BITS-1:0]  high_ff;
   logic [ENTRY_COUNT_BITS-1:0]   entries_ff;
   logic [RECIP_BITS-1:0]         recip_ff;
   logic                          ready_ff;
   logic [VALUE_BITS-1:0]         mem [TABLE_DEPTH];

   // item in flight
   req_type                       item_ff;
   logic [PW-1:0]                 pos_ff;
   logic                          lo_clamp_ff;
   logic                          hi_clamp_ff;
   logic                          zero_ff;
   status_type                    status_ff;
   logic [AW-1:0]                 addr_ff;
   logic                          interp_ff;
   logic [FRACTION_BITS-1:0]      w_ff;
   logic signed [VALUE_BITS-1:0]  rd_ff;
   logic signed [VALUE_BITS-1:0]  a_ff;
   logic signed [SW-1:0]          scale_ff;
   rsp_type                       rsp_ff;

   logic [LW-1:0]                 ent_ext;
   logic [LW-1:0]                 n_used;
   logic [LW-1:0]                 last;
   logic [LW-1:0]                 idx_ext;
   logic [LW-1:0]                 idx_clamp;
   logic                          multi;
   logic                          is_load;
   logic                          is_lookup;
   logic                          is_value;
   logic                          load_refuse;
   logic                          load_write;
   logic                          load_finish;
   logic signed [VALUE_BITS:0]    span;
   logic                          span_pos;
   logic                          recip_sat;
   logic [RECIP_BITS-1:0]         recip_direct;
   logic                          wants_div;
   logic                          wants_read;
   status_type                    status_in;
   logic [VALUE_BITS-1:0]         pos_offset;
   logic [PW-1:0]                 pos_in;
   logic                          lo_clamp_in;
   logic                          hi_clamp_in;
   logic [VALUE_BITS-1:0]         i_hi;
   logic [FRACTION_BITS-1:0]      w_in;
   logic [AW-1:0]                 addr_a;
   logic                          interp_in;
   logic [AW-1:0]                 addr_b;
   logic [AW-1:0]                 rd_addr;
   logic signed [VALUE_BITS:0]    diff;
   logic signed [SW-1:0]          scale_in;
   logic signed [SW-1:0]          rounded;
   logic signed [SW-1:0]          q_full;
   logic signed [VALUE_BITS-1:0]  result_in;
   logic                          div_done;
   logic [RECIP_BITS-1:0]         div_quo;

   // entries in use, saturated to 1..TABLE_DEPTH
   assign ent_ext = LW'(entries_ff);
   always_comb begin
      if (ent_ext == '0) begin
         n_used = LW'(1);
      end else if (ent_ext > LW'(TABLE_DEPTH)) begin
         n_used = LW'(TABLE_DEPTH);
      end else begin
         n_used = ent_ext;
      end
   end
   assign last      = n_used - LW'(1);
   assign multi     = (n_used > LW'(1));
   assign idx_ext   = LW'(item_ff.entry_index);
   assign idx_clamp = (idx_ext >= n_used) ? last : idx_ext;

   always_comb begin
      is_load   = 1'b0;
      is_lookup = 1'b0;
      is_value  = 1'b0;
      unique case (item_ff.kind)
         KIND_LOAD: begin
            is_load = 1'b1;
         end
         KIND_VALUE: begin
            is_lookup = 1'b1;
            is_value  = 1'b1;
         end
         KIND_INDEX: begin
            is_lookup = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign load_refuse = is_load && multi && (low_ff == high_ff);
   assign load_write  = is_load && !load_refuse && (idx_ext < n_used);
   assign load_finish = load_write && (idx_ext == last);

   assign span      = {high_ff[VALUE_BITS-1], high_ff} - {low_ff[VALUE_BITS-1], low_ff};
   assign span_pos  = !span[VALUE_BITS] && (span != '0);
   // (n-1) >= span means the quotient overflows the fraction
   assign recip_sat = (RECIP_BITS'(last) >= span[RECIP_BITS-1:0]);
   assign recip_direct = (!multi || !span_pos) ? '0 : '1;
   assign wants_div    = load_finish && multi && span_pos && !recip_sat;
   assign wants_read   = is_lookup && ready_ff;

   always_comb begin
      if (load_refuse) begin
         status_in = STAT_REFUSED;
      end else if (is_lookup && !ready_ff) begin
         status_in = STAT_EMPTY;
      end else begin
         status_in = STAT_OK;
      end
   end

   // fractional entry position: distance times reciprocal
   assign pos_offset  = item_ff.position - low_ff;
   assign pos_in      = pos_offset * recip_ff;
   assign lo_clamp_in = !multi || ($signed(item_ff.position) <= $signed(low_ff));
   assign hi_clamp_in = ($signed(item_ff.position) >= $signed(high_ff));

   assign i_hi = pos_ff[PW-1:VALUE_BITS];
   assign w_in = pos_ff[VALUE_BITS-FRACTION_BITS +: FRACTION_BITS];

   always_comb begin
      addr_a    = '0;
      interp_in = 1'b0;
      if (is_value) begin
         if (lo_clamp_ff) begin
            addr_a = '0;
         end else if (hi_clamp_ff || (i_hi >= VALUE_BITS'(last))) begin
            addr_a = last[AW-1:0];
         end else begin
            addr_a    = i_hi[AW-1:0];
            interp_in = 1'b1;
         end
      end else begin
         addr_a = idx_clamp[AW-1:0];
      end
   end

   assign addr_b  = interp_ff ? (addr_ff + AW'(1)) : addr_ff;
   assign rd_addr = cmd.read_a ? addr_a : addr_b;

   // blend: (b - a) * w, then round half up and add to a
   assign diff     = {rd_ff[VALUE_BITS-1], rd_ff} - {a_ff[VALUE_BITS-1], a_ff};
   assign scale_in = diff * $signed({1'b0, w_ff});
   assign rounded  = scale_ff + $signed(ROUND_HALF);
   assign q_full   = rounded >>> FRACTION_BITS;

   always_comb begin
      if (zero_ff) begin
         result_in = '0;
      end else if (interp_ff) begin
         result_in = a_ff + q_full[VALUE_BITS-1:0];
      end else begin
         result_in = a_ff;
      end
   end

   clit_recip_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.eval && wants_div),
      .numer    (RECIP_BITS'(last)),
      .denom    (span[RECIP_BITS-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // configuration registers, reciprocal and ready flag
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= '0;
         high_ff    <= '0;
         entries_ff <= ENTRY_COUNT_BITS'(1);
         recip_ff   <= '0;
         ready_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RANGE_LOW: begin
               low_ff   <= csr_wdata;
               ready_ff <= 1'b0;
            end
            CSR_RANGE_HIGH: begin
               high_ff  <= csr_wdata;
               ready_ff <= 1'b0;
            end
            CSR_ENTRIES: begin
               entries_ff <= csr_wdata[ENTRY_COUNT_BITS-1:0];
               ready_ff   <= 1'b0;
            end
            default: begin
            end
         endcase
      end else if (cmd.eval && load_finish && !wants_div) begin
         recip_ff <= recip_direct;
         ready_ff <= 1'b1;
      end else if (div_done) begin
         recip_ff <= div_quo;
         ready_ff <= 1'b1;
      end
   end

   // sample memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.eval && load_write) begin
         mem[idx_ext[AW-1:0]] <= item_ff.entry_value;
      end
      if (cmd.read_a || cmd.read_b) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_ff <= req_data;
      end
      if (cmd.eval) begin
         pos_ff      <= pos_in;
         lo_clamp_ff <= lo_clamp_in;
         hi_clamp_ff <= hi_clamp_in;
         zero_ff     <= !wants_read;
         status_ff   <= status_in;
      end
      if (cmd.read_a) begin
         addr_ff   <= addr_a;
         interp_ff <= interp_in;
         w_ff      <= w_in;
      end
      if (cmd.read_b) begin
         a_ff <= rd_ff;
      end
      if (cmd.scale) begin
         scale_ff <= scale_in;
      end
      if (cmd.deliver) begin
         rsp_ff.result_value <= result_in;
         rsp_ff.status       <= status_ff;
      end
   end

   assign stat.wants_div  = wants_div;
   assign stat.wants_read = wants_read;
   assign stat.div_done   = div_done;
   assign rsp_data        = rsp_ff;

endmodule

// File: rtl/clit_ctrl.sv
// Controller: sequences one item at a time and owns the result valid flag.
module clit_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  clit_pkg::stat_type  stat,
   output clit_pkg::cmd_type   cmd
);
   import clit_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_READ_A,
      ST_READ_B,
      ST_SCALE,
      ST_DELIVER
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd         = '0;
      cmd.take    = (state_ff == ST_IDLE) && req_valid;
      cmd.eval    = (state_ff == ST_EVAL);
      cmd.read_a  = (state_ff == ST_READ_A);
      cmd.read_b  = (state_ff == ST_READ_B);
      cmd.scale   = (state_ff == ST_SCALE);
      cmd.deliver = (state_ff == ST_DELIVER) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (stat.wants_div) begin
               state_in = ST_DIV;
            end else if (stat.wants_read) begin
               state_in = ST_READ_A;
            end else begin
               state_in = ST_DELIVER;
            end
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_DELIVER;
         end
         ST_READ_A: begin
            state_in = ST_READ_B;
         end
         ST_READ_B: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/clamped_linear_interp_table_core.sv
// Top level of the clamped linear interpolation table: controller, datapath and checks.
//
//   channel  dir  handshake            beat
//   req_     in   req_valid/req_stall  kind, position, entry_index, entry_value
//   rsp_     out  rsp_valid/rsp_stall  result_value, status
//   csr_     in   csr_write            csr_index, csr_wdata (no read-back)
//
// One item in flight; req_stall is low only while the controller is idle.
// Steps per item: a lookup of a loaded table makes two reads through the
// single memory port, then the blend multiply; loads, lookups of an unloaded
// table and unused kinds go from evaluation straight to delivery, as does a
// completing load with one entry, a non-positive span or a saturated reciprocal;
// one whose reciprocal is divided waits for the bit-serial divider.
// A finished beat waits in the result register; the next item is taken
// meanwhile and holds in its delivery step until that register frees.
// Reset is synchronous: registers back to their reset values, table not
// loaded; sample memory is not cleared and needs no clearing pass.
module clamped_linear_interp_table_core #(
   parameter int TABLE_DEPTH   = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  clit_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output clit_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write,
   input  logic [clit_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [clit_pkg::VALUE_BITS-1:0]      csr_wdata
);
   import clit_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing only; no data passes through the controller
   clit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // config registers, sample memory, multipliers, divider and result register
   clit_datapath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // an accepted beat is evaluated on the very next cycle
   a_take_then_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> cmd.eval)
      else $error("accepted beat not evaluated");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // a new result only appears through a delivery step
   a_valid_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.deliver))
      else $error("result valid without delivery");

   // nothing is taken while an item is still being worked on
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval || cmd.read_a || cmd.read_b || cmd.scale) |-> req_stall)
      else $error("input open during item work");
`endif

endmodule
